[sv/dwts_pkg.sv]
// ----------------------------------------------------------------------------
// dwts_pkg
// shared types and constants of the daily and weekly temperature statistics
// ----------------------------------------------------------------------------
package dwts_pkg;

    localparam int TEMP_W     = 8;
    localparam int DAY_SUM_W  = 14;
    localparam int WEEK_SUM_W = 19;
    localparam int MID_DEPTH  = 2;
    localparam int OUT_DEPTH  = 8;

    localparam logic [2:0]              HOT_LIMIT   = 3'd7;
    localparam logic signed [TEMP_W-1:0] THRESH_INIT = 8'sd30;

    typedef enum logic
    {
        REPORT_DAY  = 1'b0,
        REPORT_WEEK = 1'b1
    } report_kind_t;

    typedef struct packed
    {
        logic [2:0]                     day_number;
        logic                           week_end;
        logic signed [TEMP_W-1:0]       day_max;
        logic signed [TEMP_W-1:0]       day_min;
        logic signed [DAY_SUM_W-1:0]    day_sum;
        logic signed [TEMP_W-1:0]       week_max;
        logic signed [TEMP_W-1:0]       week_min;
        logic signed [WEEK_SUM_W-1:0]   week_sum;
    } day_rec_t;

    typedef struct packed
    {
        logic [2:0]                 day_number;
        logic                       week_end;
        logic signed [TEMP_W-1:0]   day_max;
        logic signed [TEMP_W-1:0]   day_min;
        logic signed [TEMP_W-1:0]   day_mean;
        logic signed [TEMP_W-1:0]   week_max;
        logic signed [TEMP_W-1:0]   week_min;
        logic signed [TEMP_W-1:0]   week_mean;
        logic [2:0]                 hot_days;
    } summary_t;

endpackage

[sv/dwts_fifo.sv]
// ----------------------------------------------------------------------------
// dwts_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module dwts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [WIDTH-1:0]                wr_data,
    output logic                            full,
    input  logic                            rd_en,
    output logic [WIDTH-1:0]                rd_data,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/dwts_front.sv]
// ----------------------------------------------------------------------------
// dwts_front
// per-sample accumulation of day and week max, min and sum
// ----------------------------------------------------------------------------
module dwts_front #(
    parameter int SAMPLES_PER_DAY = 24,
    parameter int DAYS_PER_WEEK   = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [dwts_pkg::TEMP_W-1:0]  temperature,
    input  logic                                push,
    output logic                                full,
    input  logic                                rec_full,
    output logic                                rec_push,
    output dwts_pkg::day_rec_t                  rec
);

    localparam int HW = (SAMPLES_PER_DAY > 1) ? $clog2(SAMPLES_PER_DAY) : 1;
    localparam int DW = (DAYS_PER_WEEK > 1) ? $clog2(DAYS_PER_WEEK) : 1;
    localparam int DSW = dwts_pkg::DAY_SUM_W;
    localparam int WSW = dwts_pkg::WEEK_SUM_W;
    localparam logic [HW-1:0] LAST_HOUR = HW'(SAMPLES_PER_DAY - 1);
    localparam logic [DW-1:0] LAST_DAY  = DW'(DAYS_PER_WEEK - 1);

    logic [HW-1:0]                      hour_reg, hour_next;
    logic [DW-1:0]                      day_reg, day_next;
    logic signed [dwts_pkg::TEMP_W-1:0] dmax_reg, dmin_reg, wmax_reg, wmin_reg;
    logic signed [dwts_pkg::TEMP_W-1:0] dmax_next, dmin_next, wmax_next, wmin_next;
    logic signed [DSW-1:0]              dsum_reg, dsum_next;
    logic signed [WSW-1:0]              wsum_reg, wsum_next;
    logic                               first_day, first_week;
    logic                               day_end, week_end, accept;

    assign first_day  = (hour_reg == '0);
    assign first_week = first_day && (day_reg == '0);
    assign day_end    = (hour_reg == LAST_HOUR);
    assign week_end   = (day_reg == LAST_DAY);
    assign full       = rec_full && day_end;
    assign accept     = push && !full;
    assign rec_push   = accept && day_end;

    always_comb
    begin
        dmax_next = (first_day || temperature > dmax_reg) ? temperature : dmax_reg;
        dmin_next = (first_day || temperature < dmin_reg) ? temperature : dmin_reg;
        wmax_next = (first_week || temperature > wmax_reg) ? temperature : wmax_reg;
        wmin_next = (first_week || temperature < wmin_reg) ? temperature : wmin_reg;
        dsum_next = (first_day ? DSW'(0) : dsum_reg) + DSW'(temperature);
        wsum_next = (first_week ? WSW'(0) : wsum_reg) + WSW'(temperature);
        hour_next = day_end ? '0 : hour_reg + 1'b1;
        day_next  = day_reg;
        if (day_end)
        begin
            day_next = week_end ? '0 : day_reg + 1'b1;
        end
    end

    always_comb
    begin
        rec.day_number = 3'(day_reg);
        rec.week_end   = week_end;
        rec.day_max    = dmax_next;
        rec.day_min    = dmin_next;
        rec.day_sum    = dsum_next;
        rec.week_max   = wmax_next;
        rec.week_min   = wmin_next;
        rec.week_sum   = wsum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg <= '0;
            day_reg  <= '0;
        end
        else if (accept)
        begin
            hour_reg <= hour_next;
            day_reg  <= day_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dmax_reg <= dmax_next;
            dmin_reg <= dmin_next;
            wmax_reg <= wmax_next;
            wmin_reg <= wmin_next;
            dsum_reg <= dsum_next;
            wsum_reg <= wsum_next;
        end
    end

endmodule

[sv/dwts_div.sv]
// ----------------------------------------------------------------------------
// dwts_div
// three-stage signed division by a constant, truncating toward zero
// ----------------------------------------------------------------------------
module dwts_div #(
    parameter int IN_W    = 14,
    parameter int DIVISOR = 24
) (
    input  logic                                clk,
    input  logic signed [IN_W-1:0]              value,
    output logic signed [dwts_pkg::TEMP_W-1:0]  quotient
);

    localparam int AW  = IN_W;
    localparam int K   = IN_W;
    localparam int MW  = K + 1;
    localparam int PW  = AW + MW;
    localparam logic [MW-1:0] RECIP = MW'((2 ** K) / DIVISOR);
    localparam logic [AW-1:0] DIV_C = AW'(DIVISOR);

    logic [AW-1:0]  mag;
    logic [PW-1:0]  prod_reg;
    logic [AW-1:0]  a1_reg, a2_reg;
    logic           neg1_reg, neg2_reg;
    logic [AW-1:0]  q0_reg, qd_reg;
    logic [AW-1:0]  q0_s2;
    logic [AW-1:0]  rem, q, sq;

    assign mag   = value[IN_W-1] ? (~AW'(value) + 1'b1) : AW'(value);
    assign q0_s2 = prod_reg[K +: AW];
    assign rem   = a2_reg - qd_reg;
    assign q     = q0_reg + AW'(rem >= DIV_C);
    assign sq    = neg2_reg ? (~q + 1'b1) : q;

    always_ff @(posedge clk)
    begin
        // reciprocal product
        prod_reg <= PW'(mag) * PW'(RECIP);
        a1_reg   <= mag;
        neg1_reg <= value[IN_W-1];
        // estimate times divisor, estimate is low by at most one
        q0_reg   <= q0_s2;
        qd_reg   <= q0_s2 * DIV_C;
        a2_reg   <= a1_reg;
        neg2_reg <= neg1_reg;
        // correct and restore sign
        quotient <= sq[dwts_pkg::TEMP_W-1:0];
    end

endmodule

[sv/dwts_back.sv]
// ----------------------------------------------------------------------------
// dwts_back
// means, hot-day count and result queue with day/week serialization
// ----------------------------------------------------------------------------
module dwts_back #(
    parameter int SAMPLES_PER_DAY = 24,
    parameter int DAYS_PER_WEEK   = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwts_pkg::day_rec_t                  rec,
    input  logic                                rec_empty,
    output logic                                rec_pop,
    input  logic signed [dwts_pkg::TEMP_W-1:0]  hot_threshold,
    output logic                                report_kind,
    output logic [2:0]                          day_number,
    output logic signed [dwts_pkg::TEMP_W-1:0]  max_temp,
    output logic signed [dwts_pkg::TEMP_W-1:0]  min_temp,
    output logic signed [dwts_pkg::TEMP_W-1:0]  mean_temp,
    output logic [2:0]                          hot_day_count,
    output logic                                final_of_run,
    output logic                                empty,
    input  logic                                pop
);

    localparam int CW = $clog2(dwts_pkg::OUT_DEPTH + 1);
    localparam int SW = $bits(dwts_pkg::summary_t);

    dwts_pkg::day_rec_t                 s1_reg, s2_reg, s3_reg;
    logic                               v1_reg, v2_reg, v3_reg;
    logic signed [dwts_pkg::TEMP_W-1:0] day_mean, week_mean;
    logic [2:0]                         hot_reg, hot_next, hot_after;
    logic                               hot_inc;
    logic [CW-1:0]                      out_count;
    logic [CW:0]                        reserved;
    dwts_pkg::summary_t                 wr_sum, head;
    logic [SW-1:0]                      head_bits;
    logic                               out_empty, out_rd;
    logic                               phase_reg, phase_next;

    assign reserved = (CW+1)'(out_count) + (CW+1)'(v1_reg) + (CW+1)'(v2_reg)
                    + (CW+1)'(v3_reg);
    assign rec_pop  = !rec_empty && (reserved < (CW+1)'(dwts_pkg::OUT_DEPTH));

    dwts_div #(
        .IN_W    (dwts_pkg::DAY_SUM_W),
        .DIVISOR (SAMPLES_PER_DAY)
    ) u_day_div (
        .clk      (clk),
        .value    (rec.day_sum),
        .quotient (day_mean)
    );

    dwts_div #(
        .IN_W    (dwts_pkg::WEEK_SUM_W),
        .DIVISOR (SAMPLES_PER_DAY * DAYS_PER_WEEK)
    ) u_week_div (
        .clk      (clk),
        .value    (rec.week_sum),
        .quotient (week_mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            hot_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= rec_pop;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            hot_reg   <= hot_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= rec;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
    end

    always_comb
    begin
        hot_inc   = (day_mean > hot_threshold) && (hot_reg != dwts_pkg::HOT_LIMIT);
        hot_after = hot_reg + 3'(hot_inc);
        hot_next  = hot_reg;
        if (v3_reg)
        begin
            hot_next = s3_reg.week_end ? '0 : hot_after;
        end
        wr_sum.day_number = s3_reg.day_number;
        wr_sum.week_end   = s3_reg.week_end;
        wr_sum.day_max    = s3_reg.day_max;
        wr_sum.day_min    = s3_reg.day_min;
        wr_sum.day_mean   = day_mean;
        wr_sum.week_max   = s3_reg.week_max;
        wr_sum.week_min   = s3_reg.week_min;
        wr_sum.week_mean  = week_mean;
        wr_sum.hot_days   = hot_after;
    end

    dwts_fifo #(
        .WIDTH (SW),
        .DEPTH (dwts_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (v3_reg),
        .wr_data (wr_sum),
        .full    (),
        .rd_en   (out_rd),
        .rd_data (head_bits),
        .empty   (out_empty),
        .count   (out_count)
    );

    assign head = dwts_pkg::summary_t'(head_bits);

    // week summary follows the day summary of the same entry
    always_comb
    begin
        out_rd     = 1'b0;
        phase_next = phase_reg;
        if (pop && !out_empty)
        begin
            if (!phase_reg && head.week_end)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                out_rd     = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        empty         = out_empty;
        day_number    = head.day_number;
        report_kind   = phase_reg ? dwts_pkg::REPORT_WEEK : dwts_pkg::REPORT_DAY;
        max_temp      = phase_reg ? head.week_max : head.day_max;
        min_temp      = phase_reg ? head.week_min : head.day_min;
        mean_temp     = phase_reg ? head.week_mean : head.day_mean;
        hot_day_count = phase_reg ? head.hot_days : 3'd0;
        final_of_run  = phase_reg || !head.week_end;
    end

endmodule

[sv/daily_weekly_temperature_stats.sv]
// ----------------------------------------------------------------------------
// daily_weekly_temperature_stats
// hourly samples in, day and week max/min/mean summaries out
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            temperature
//  result    empty / pop            report_kind, day_number, max_temp, min_temp,
//                                   mean_temp, hot_day_count, final_of_run
//  config    cfg_valid / cfg_ready  cfg_data (hot threshold)
//
//  one sample per cycle while full is low; a day's last sample has its summary on the
//  result ports after the record queue, three divider stages and the result queue
//  full rises only on a day's last sample when the record queue is full
//  the back end admits a record only with room reserved in the result queue
//  a week-end entry leaves as two results, day then week
//  reset clears counters, queues and the hot-day count; threshold resets to 30
// ----------------------------------------------------------------------------
module daily_weekly_temperature_stats #(
    parameter int SAMPLES_PER_DAY = 24,
    parameter int DAYS_PER_WEEK   = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [dwts_pkg::TEMP_W-1:0]  temperature,
    input  logic                                push,
    output logic                                full,
    output logic                                report_kind,
    output logic [2:0]                          day_number,
    output logic signed [dwts_pkg::TEMP_W-1:0]  max_temp,
    output logic signed [dwts_pkg::TEMP_W-1:0]  min_temp,
    output logic signed [dwts_pkg::TEMP_W-1:0]  mean_temp,
    output logic [2:0]                          hot_day_count,
    output logic                                final_of_run,
    output logic                                empty,
    input  logic                                pop,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic signed [dwts_pkg::TEMP_W-1:0]  cfg_data
);

    localparam int RW = $bits(dwts_pkg::day_rec_t);

    dwts_pkg::day_rec_t                 front_rec, mid_rec;
    logic [RW-1:0]                      mid_bits;
    logic                               rec_push, rec_full, rec_empty, rec_pop;
    logic signed [dwts_pkg::TEMP_W-1:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= dwts_pkg::THRESH_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    dwts_front #(
        .SAMPLES_PER_DAY (SAMPLES_PER_DAY),
        .DAYS_PER_WEEK   (DAYS_PER_WEEK)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .temperature (temperature),
        .push        (push),
        .full        (full),
        .rec_full    (rec_full),
        .rec_push    (rec_push),
        .rec         (front_rec)
    );

    dwts_fifo #(
        .WIDTH (RW),
        .DEPTH (dwts_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (front_rec),
        .full    (rec_full),
        .rd_en   (rec_pop),
        .rd_data (mid_bits),
        .empty   (rec_empty),
        .count   ()
    );

    assign mid_rec = dwts_pkg::day_rec_t'(mid_bits);

    dwts_back #(
        .SAMPLES_PER_DAY (SAMPLES_PER_DAY),
        .DAYS_PER_WEEK   (DAYS_PER_WEEK)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (mid_rec),
        .rec_empty     (rec_empty),
        .rec_pop       (rec_pop),
        .hot_threshold (thresh_reg),
        .report_kind   (report_kind),
        .day_number    (day_number),
        .max_temp      (max_temp),
        .min_temp      (min_temp),
        .mean_temp     (mean_temp),
        .hot_day_count (hot_day_count),
        .final_of_run  (final_of_run),
        .empty         (empty),
        .pop           (pop)
    );

endmodule
